[rtl/trq_pkg.sv]
package trq_pkg;

  localparam int unsigned QueueDepthDef = 64;

  localparam logic [15:0] EvtSyn       = 16'd0;
  localparam logic [15:0] EvtKey       = 16'd1;
  localparam logic [15:0] EvtAbs       = 16'd3;
  localparam logic [15:0] CodeTouch    = 16'd330;
  localparam logic [15:0] CodeX        = 16'd0;
  localparam logic [15:0] CodeY        = 16'd1;
  localparam logic [15:0] CodePressure = 16'd24;
  localparam logic [15:0] CodeReport   = 16'd0;
  localparam logic [11:0] CoordMax     = 12'd4095;
  localparam int unsigned DivSteps     = 31;

  typedef enum logic [2:0] {
    RegXZero  = 3'd0,
    RegXFull  = 3'd1,
    RegYZero  = 3'd2,
    RegYFull  = 3'd3,
    RegWidth  = 3'd4,
    RegHeight = 3'd5
  } trq_reg_e;

  typedef enum logic [3:0] {
    StIdle, StSetup, StMul, StDivInit, StDiv, StAxisEnd, StFinish, StPush, StPopRead
  } trq_state_e;

  typedef struct packed {
    logic               func;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [15:0] event_value;
  } trq_in_t;

  typedef struct packed {
    logic               report_found;
    logic [11:0]        point_x;
    logic [11:0]        point_y;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic               pressed;
    logic               more_pending;
  } trq_out_t;

  typedef struct packed {
    logic [11:0]        px;
    logic [11:0]        py;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic               pr;
  } trq_report_t;

endpackage

[rtl/touch_report_queue_core.sv]
// Touch event filter with a report queue.
// Axis and key events and empty-queue pops are handled in the idle state; a queued pop shows its
// result through the synchronous memory read, then the output register.
// A sync report stalls the input while it is mapped and queued: per axis one multiply and
// a 31-step restoring divider shared by X and Y, then one or two queue writes.
// Reset is asynchronous, active low: calibration defaults, empty queue, memory not cleared.
module touch_report_queue_core #(
  parameter int unsigned QUEUE_DEPTH = trq_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  trq_pkg::trq_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output trq_pkg::trq_out_t out_data_o
);
  import trq_pkg::*;

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DepthW = (CW + 1)'(QUEUE_DEPTH);

  // Calibration registers
  logic signed [15:0] x_zero_q, x_full_q, y_zero_q, y_full_q;
  logic [12:0]        width_q, height_q;

  // Event state
  logic               touch_down_q, have_x_q, have_y_q, have_p_q, contact_q, p_pos_q;
  logic signed [15:0] last_x_q, last_y_q;
  trq_report_t        cur_q;

  // Queue
  trq_report_t        mem [QUEUE_DEPTH];
  trq_report_t        rdata_q;
  logic [IW-1:0]      rd_idx_q;
  logic [CW-1:0]      count_q;
  logic               more_q;

  // Mapping datapath
  trq_state_e         state_q, state_d;
  logic               axis_q;
  logic [15:0]        absd_q, den_q;
  logic [12:0]        extm_q, lim_q;
  logic               degen_q;
  logic [28:0]        num_q;
  logic [30:0]        quo_q;
  logic [17:0]        rem_q;
  logic [16:0]        dvs_q;
  logic [4:0]         dcnt_q;
  logic [11:0]        px_q;

  logic               out_valid_q;
  trq_out_t           out_q;

  logic               in_acc, out_free;
  logic               is_sync, is_pop;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle) || !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_pop      = in_data_i.func;
  assign is_sync     = !is_pop && in_data_i.event_type == EvtSyn &&
                       in_data_i.event_code == CodeReport;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Select and prepare the active axis
  logic signed [15:0] s_raw, s_zero, s_full, s_lo, s_hi, s_c;
  logic [12:0]        s_ext;
  logic signed [16:0] s_diff, s_span;
  always_comb begin
    s_raw  = axis_q ? last_y_q : last_x_q;
    s_zero = axis_q ? y_zero_q : x_zero_q;
    s_full = axis_q ? y_full_q : x_full_q;
    s_ext  = axis_q ? height_q : width_q;
    s_lo   = (s_zero < s_full) ? s_zero : s_full;
    s_hi   = (s_zero < s_full) ? s_full : s_zero;
    s_c    = (s_raw < s_lo) ? s_lo : ((s_raw > s_hi) ? s_hi : s_raw);
    s_diff = 17'(s_c) - 17'(s_zero);
    s_span = 17'(s_full) - 17'(s_zero);
  end

  // Divider step: shift in one dividend bit, subtract if it fits
  logic [17:0] d_shift;
  logic [18:0] d_trial;
  assign d_shift = {rem_q[16:0], quo_q[30]};
  assign d_trial = {1'b0, d_shift} - {2'b00, dvs_q};

  // Rounded quotient, clamped to the extent and the coordinate range; zero for a degenerate span
  logic [11:0] q_clamped;
  always_comb begin
    if (degen_q) begin
      q_clamped = '0;
    end else if (quo_q > 31'(lim_q)) begin
      q_clamped = (lim_q > 13'(CoordMax)) ? CoordMax : lim_q[11:0];
    end else if (quo_q > 31'(CoordMax)) begin
      q_clamped = CoordMax;
    end else begin
      q_clamped = quo_q[11:0];
    end
  end

  logic        new_pr;
  trq_report_t new_rep;
  logic        q_full;
  logic [CW:0] wsum;
  logic [IW-1:0] waddr;
  always_comb begin
    new_pr  = touch_down_q && have_x_q && have_y_q && have_p_q && p_pos_q;
    new_rep = '{px: px_q, py: q_clamped, rx: last_x_q, ry: last_y_q, pr: contact_q};
    q_full  = count_q >= DepthC;
    wsum    = (CW + 1)'(rd_idx_q) + (CW + 1)'(count_q);
    if (wsum >= DepthW) wsum = wsum - DepthW;
    waddr   = wsum[IW-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && is_pop && count_q != '0) state_d = StPopRead;
        else if (in_acc && is_sync) state_d = StSetup;
      end
      StSetup:   state_d = StMul;
      StMul:     state_d = StDivInit;
      StDivInit: state_d = StDiv;
      StDiv:     if (dcnt_q == 5'(DivSteps - 1)) state_d = StAxisEnd;
      StAxisEnd: state_d = axis_q ? StFinish : StSetup;
      StFinish:  state_d = StPush;
      StPush:    state_d = StIdle;
      StPopRead: state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_zero_q <= 16'sd0;
      x_full_q <= 16'sd4095;
      y_zero_q <= 16'sd0;
      y_full_q <= 16'sd4095;
      width_q  <= 13'd480;
      height_q <= 13'd320;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegXZero:  x_zero_q <= cfg_data_i;
        RegXFull:  x_full_q <= cfg_data_i;
        RegYZero:  y_zero_q <= cfg_data_i;
        RegYFull:  y_full_q <= cfg_data_i;
        RegWidth:  width_q  <= cfg_data_i[12:0];
        RegHeight: height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Event latches, queue pointers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_down_q <= 1'b0;
      have_x_q     <= 1'b0;
      have_y_q     <= 1'b0;
      have_p_q     <= 1'b0;
      contact_q    <= 1'b0;
      p_pos_q      <= 1'b0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      cur_q        <= '0;
      rd_idx_q     <= '0;
      count_q      <= '0;
      more_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      axis_q       <= 1'b0;
      dcnt_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_acc && !is_pop) begin
            if (in_data_i.event_type == EvtKey && in_data_i.event_code == CodeTouch) begin
              touch_down_q <= in_data_i.event_value != 16'sd0;
              if (in_data_i.event_value != 16'sd0) begin
                have_x_q <= 1'b0;
                have_y_q <= 1'b0;
                have_p_q <= 1'b0;
              end
              contact_q <= 1'b0;
            end else if (in_data_i.event_type == EvtAbs) begin
              if (in_data_i.event_code == CodeX) begin
                last_x_q <= in_data_i.event_value;
                have_x_q <= 1'b1;
              end else if (in_data_i.event_code == CodeY) begin
                last_y_q <= in_data_i.event_value;
                have_y_q <= 1'b1;
              end else if (in_data_i.event_code == CodePressure) begin
                p_pos_q  <= in_data_i.event_value > 16'sd0;
                have_p_q <= 1'b1;
              end
            end else if (is_sync) begin
              contact_q <= new_pr;
              axis_q    <= 1'b0;
            end
          end else if (in_acc && is_pop) begin
            if (count_q != '0) begin
              more_q   <= count_q > CW'(1);
              count_q  <= count_q - CW'(1);
              rd_idx_q <= (rd_idx_q == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_q + IW'(1);
            end else begin
              // Empty queue: return the current report
              out_valid_q <= 1'b1;
              out_q <= '{report_found: 1'b0, point_x: cur_q.px, point_y: cur_q.py,
                         raw_x: cur_q.rx, raw_y: cur_q.ry, pressed: cur_q.pr,
                         more_pending: 1'b0};
            end
          end
        end
        StDivInit: dcnt_q <= '0;
        StDiv:     dcnt_q <= dcnt_q + 5'd1;
        StAxisEnd: axis_q <= 1'b1;
        StFinish: begin
          cur_q <= new_rep;
          if (q_full) begin
            rd_idx_q <= '0;
            count_q  <= new_rep.pr ? CW'(1) : '0;
          end
        end
        StPush:    count_q <= count_q + CW'(1);
        StPopRead: begin
          out_valid_q <= 1'b1;
          out_q <= '{report_found: 1'b1, point_x: rdata_q.px, point_y: rdata_q.py,
                     raw_x: rdata_q.rx, raw_y: rdata_q.ry, pressed: rdata_q.pr,
                     more_pending: more_q};
        end
        default: ;
      endcase
    end
  end

  // Mapping datapath: prepare, multiply, then restoring divide
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StSetup: begin
        degen_q <= (s_ext <= 13'd1) || (s_zero == s_full);
        absd_q  <= s_diff[16] ? 16'(-s_diff) : s_diff[15:0];
        den_q   <= s_span[16] ? 16'(-s_span) : s_span[15:0];
        extm_q  <= s_ext - 13'd1;
        lim_q   <= s_ext - 13'd1;
      end
      StMul:     num_q <= 29'(absd_q) * 29'(extm_q);
      StDivInit: begin
        quo_q <= {1'b0, num_q, 1'b0} + 31'(den_q);
        rem_q <= '0;
        dvs_q <= {den_q, 1'b0};
      end
      StDiv: begin
        quo_q <= {quo_q[29:0], ~d_trial[18]};
        rem_q <= d_trial[18] ? d_shift : d_trial[17:0];
      end
      // Keep the X column; the Y row is taken straight from the clamp in StFinish
      StAxisEnd: if (!axis_q) px_q <= q_clamped;
      default: ;
    endcase
  end

  // Report memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == StFinish && q_full && new_rep.pr) begin
      mem[0] <= '{px: new_rep.px, py: new_rep.py, rx: new_rep.rx, ry: new_rep.ry, pr: 1'b0};
    end else if (state_q == StPush) begin
      mem[waddr] <= cur_q;
    end
    if (in_acc && is_pop) rdata_q <= mem[rd_idx_q];
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("queue count above depth");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> in_stall_o) else $error("input taken while busy");
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StPopRead |=> out_valid_q && out_q.report_found)
    else $error("queued pop gave no result");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> dcnt_q < 5'(DivSteps)) else $error("divider overran");
`endif

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trq_pkg::*;

  // Register indexes past the last register; writes there must be dropped.
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;
  localparam int unsigned Depth = QueueDepthDef;
  localparam int unsigned CycleLimit = 1000000;
  // A sync report runs with the input stalled and gives no result; let it settle before config.
  localparam int unsigned SettleCycles = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  trq_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  trq_out_t    out_data_o;

  touch_report_queue_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the calibration and the filter state.
  logic signed [15:0] cal_x_zero, cal_x_full, cal_y_zero, cal_y_full;
  logic [12:0]        cal_width, cal_height;
  logic               st_touch, st_have_x, st_have_y, st_have_p, st_contact, st_p_pos;
  logic signed [15:0] st_raw_x, st_raw_y;
  trq_report_t        st_current;
  trq_report_t        st_store [Depth];
  int unsigned        st_rd_idx, st_count;

  trq_out_t    pending_reports[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  bit          idle_en = 1'b1;
  int unsigned stall_left = 0;

  // Map one raw sample to a pixel: clamp into the calibrated span, scale with
  // rounding half away from zero, then clamp to the extent and to 12 bits.
  function automatic logic [11:0] map_axis(logic signed [15:0] raw, logic signed [15:0] zero,
                                           logic signed [15:0] full, logic [12:0] ext);
    longint lo, hi, c, num, den, q;
    if (ext <= 13'd1 || zero == full) return 12'd0;
    lo = (zero < full) ? zero : full;
    hi = (zero < full) ? full : zero;
    c = raw;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    num = (c - longint'(zero)) * (longint'(ext) - 1);
    den = longint'(full) - longint'(zero);
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    q = (num * 2 + den) / (den * 2);
    if (q > longint'(ext) - 1) q = longint'(ext) - 1;
    if (q > 4095) q = 4095;
    return q[11:0];
  endfunction

  function automatic void queue_report(trq_report_t r);
    st_store[(st_rd_idx + st_count) % Depth] = r;
    st_count++;
  endfunction

  // Advance the shadow state by one accepted transaction; pops add an expectation.
  function automatic void track_transaction(trq_in_t it);
    trq_report_t rel;
    trq_report_t r;
    trq_out_t    o;
    if (!it.func) begin
      if (it.event_type == EvtKey && it.event_code == CodeTouch) begin
        st_touch = (it.event_value != 0);
        if (st_touch) begin
          st_have_x = 1'b0;
          st_have_y = 1'b0;
          st_have_p = 1'b0;
        end
        st_contact = 1'b0;
      end else if (it.event_type == EvtAbs) begin
        if (it.event_code == CodeX) begin
          st_raw_x = it.event_value;
          st_have_x = 1'b1;
        end else if (it.event_code == CodeY) begin
          st_raw_y = it.event_value;
          st_have_y = 1'b1;
        end else if (it.event_code == CodePressure) begin
          st_p_pos = (it.event_value > 0);
          st_have_p = 1'b1;
        end
      end else if (it.event_type == EvtSyn && it.event_code == CodeReport) begin
        st_contact = st_touch && st_have_x && st_have_y && st_have_p && st_p_pos;
        st_current.px = map_axis(st_raw_x, cal_x_zero, cal_x_full, cal_width);
        st_current.py = map_axis(st_raw_y, cal_y_zero, cal_y_full, cal_height);
        st_current.rx = st_raw_x;
        st_current.ry = st_raw_y;
        st_current.pr = st_contact;
        if (st_count >= Depth) begin
          st_rd_idx = 0;
          st_count = 0;
          if (st_current.pr) begin
            rel = st_current;
            rel.pr = 1'b0;
            queue_report(rel);
          end
        end
        queue_report(st_current);
      end
      return;
    end
    if (st_count > 0) begin
      r = st_store[st_rd_idx];
      st_rd_idx = (st_rd_idx + 1) % Depth;
      st_count--;
      o.report_found = 1'b1;
    end else begin
      r = st_current;
      o.report_found = 1'b0;
    end
    o.point_x = r.px;
    o.point_y = r.py;
    o.raw_x = r.rx;
    o.raw_y = r.ry;
    o.pressed = r.pr;
    o.more_pending = (st_count > 0);
    pending_reports = {pending_reports, o};
  endfunction

  // Receiver side: random stall bursts, changed on the falling edge.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted report with the oldest expectation.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected report: %p", out_data_o);
      end else begin
        trq_out_t exp_rep;
        exp_rep = pending_reports[0];
        pending_reports.delete(0);
        if (out_data_o.report_found !== exp_rep.report_found ||
            out_data_o.point_x !== exp_rep.point_x || out_data_o.point_y !== exp_rep.point_y ||
            out_data_o.raw_x !== exp_rep.raw_x || out_data_o.raw_y !== exp_rep.raw_y ||
            out_data_o.pressed !== exp_rep.pressed ||
            out_data_o.more_pending !== exp_rep.more_pending) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("report mismatch: expected %p, got %p", exp_rep, out_data_o);
        end
      end
    end
  end

  // Send one transaction; an idle burst may come first. Hold valid and data until
  // the block takes them, then advance the shadow model.
  task automatic send_item(trq_in_t it);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    track_transaction(it);
  endtask

  task automatic send_event(logic [15:0] etype, logic [15:0] ecode, logic [15:0] evalue);
    trq_in_t it;
    it.func = 1'b0;
    it.event_type = etype;
    it.event_code = ecode;
    it.event_value = evalue;
    send_item(it);
  endtask

  task automatic send_pop();
    trq_in_t     it;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    it = trq_in_t'(rnd[48:0]);
    it.func = 1'b1;
    send_item(it);
  endtask

  // Drop valid, wait for every report, then let a trailing sync report finish.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegXZero:  cal_x_zero = data;
      RegXFull:  cal_x_full = data;
      RegYZero:  cal_y_zero = data;
      RegYFull:  cal_y_full = data;
      RegWidth:  cal_width = data[12:0];
      RegHeight: cal_height = data[12:0];
      default: ;
    endcase
  endtask

  task automatic load_cal(logic [15:0] xz, logic [15:0] xf, logic [15:0] yz,
                          logic [15:0] yf, logic [15:0] w, logic [15:0] h);
    write_reg(RegXZero, xz);
    write_reg(RegXFull, xf);
    write_reg(RegYZero, yz);
    write_reg(RegYFull, yf);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
  endtask

  // Pick a raw sample: mostly inside the span, sometimes anywhere or at an end.
  function automatic logic [15:0] pick_raw(logic signed [15:0] zero, logic signed [15:0] full);
    int lo, hi;
    lo = (zero < full) ? zero : full;
    hi = (zero < full) ? full : zero;
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return zero;
      2: return full;
      default: return 16'(int'($urandom_range(0, hi - lo)) + lo);
    endcase
  endfunction

  // One touch frame: optional press, samples, sync; sometimes a release frame.
  task automatic send_frame();
    if ($urandom_range(0, 2) == 0) send_event(EvtKey, CodeTouch, $urandom_range(0, 3) == 0 ?
                                              16'($urandom) : 16'd1);
    if ($urandom_range(0, 7) != 0) send_event(EvtAbs, CodeX, pick_raw(cal_x_zero, cal_x_full));
    if ($urandom_range(0, 7) != 0) send_event(EvtAbs, CodeY, pick_raw(cal_y_zero, cal_y_full));
    if ($urandom_range(0, 7) != 0)
      send_event(EvtAbs, CodePressure, $urandom_range(0, 3) == 0 ? 16'($urandom) :
                 16'($urandom_range(0, 255)));
    send_event(EvtSyn, CodeReport, 16'($urandom));
    if ($urandom_range(0, 4) == 0) begin
      send_event(EvtKey, CodeTouch, 16'd0);
      send_event(EvtSyn, CodeReport, 16'd0);
    end
  endtask

  // Mixed traffic: frames, pop bursts, noise, and now and then a flood of sync
  // reports that can overrun the queue. Runs until about n transactions are sent.
  task automatic run_traffic(int unsigned n, bit with_flood);
    int unsigned start;
    int unsigned sel;
    start = items_sent;
    while (items_sent - start < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        send_frame();
      end else if (sel < 80) begin
        repeat ($urandom_range(1, 4)) send_pop();
      end else if (sel < 90) begin
        send_event($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4)),
                   $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 25)),
                   16'($urandom));
      end else if (sel < 97 || !with_flood) begin
        send_event(EvtKey, CodeTouch, 16'($urandom));
      end else begin
        send_frame();
        repeat ($urandom_range(62, 70)) send_event(EvtSyn, CodeReport, 16'd0);
        repeat ($urandom_range(2, 8)) send_pop();
      end
    end
  endtask

  task automatic test_reset_defaults();
    // Pop on empty after reset returns the all-zero current report.
    send_pop();
    send_event(EvtKey, CodeTouch, 16'd1);
    send_event(EvtAbs, CodeX, 16'h8000);
    send_event(EvtAbs, CodeY, 16'h7fff);
    send_event(EvtAbs, CodePressure, 16'd1);
    send_event(EvtSyn, CodeReport, 16'd0);
    send_event(EvtAbs, CodeX, 16'd2048);
    send_event(EvtAbs, CodeY, 16'd4095);
    send_event(EvtAbs, CodePressure, 16'h8000);
    send_event(EvtSyn, CodeReport, 16'd0);
    // Release keeps latches; sync then reports unpressed.
    send_event(EvtKey, CodeTouch, 16'd0);
    send_event(EvtSyn, CodeReport, 16'd0);
    // Unknown type and code are ignored.
    send_event(16'd2, CodeX, 16'd5);
    send_event(EvtAbs, 16'hffff, 16'd5);
    send_event(EvtSyn, 16'd1, 16'd0);
    send_event(16'hffff, 16'hffff, 16'hffff);
    repeat (5) send_pop();
    // Register indexes past the end do nothing.
    drain();
    write_reg(RegSpareLo, 16'hffff);
    write_reg(RegSpareHi, 16'h1234);
    run_traffic(200, 1'b1);
    drain();
  endtask

  task automatic test_full_span();
    load_cal(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'd4096, 16'd4096);
    run_traffic(150, 1'b1);
    // Hold off until every report is back, then continue.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    run_traffic(100, 1'b0);
    drain();
  endtask

  task automatic test_reversed_span();
    load_cal(16'h7fff, 16'h8000, 16'd3900, 16'd150, 16'd800, 16'd2);
    run_traffic(200, 1'b1);
    drain();
  endtask

  task automatic test_degenerate_span();
    load_cal(16'd100, 16'd100, 16'd0, 16'd4095, 16'd0, 16'd1);
    run_traffic(120, 1'b0);
    drain();
    load_cal(16'd0, 16'd1, 16'hffff, 16'hffff, 16'd2, 16'd300);
    run_traffic(120, 1'b0);
    drain();
  endtask

  task automatic test_oversized_extent();
    load_cal(16'd0, 16'd4095, 16'hf000, 16'h0fff, 16'h1fff, 16'hffff);
    run_traffic(200, 1'b1);
    drain();
  endtask

  task automatic test_random_calibration();
    repeat (3) begin
      load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)));
      run_traffic(100, 1'b1);
      drain();
    end
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    load_cal(16'd0, 16'd4095, 16'd0, 16'd4095, 16'd480, 16'd320);
    run_traffic(150, 1'b1);
    drain();
  endtask

  initial begin
    cal_x_zero = 16'sd0;
    cal_x_full = 16'sd4095;
    cal_y_zero = 16'sd0;
    cal_y_full = 16'sd4095;
    cal_width = 13'd480;
    cal_height = 13'd320;
    {st_touch, st_have_x, st_have_y, st_have_p, st_contact, st_p_pos} = '0;
    st_raw_x = '0;
    st_raw_y = '0;
    st_current = '0;
    st_rd_idx = 0;
    st_count = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_full_span();
    test_reversed_span();
    test_degenerate_span();
    test_oversized_extent();
    test_random_calibration();
    test_no_idle();

    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
